// ----- rtl/rrts_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared sizes, codes and types for the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    // Table size and derived widths
    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FILL_W     = $clog2(SLOT_COUNT + 1);

    // Fixed field widths
    localparam int REQ_W      = 2;
    localparam int FRAME_W    = 32;
    localparam int ID_W       = 32;
    localparam int QTM_W      = 16;
    localparam int OUT_SLOT_W = 4;

    localparam logic [QTM_W-1:0] QUANTUM_RESET = 16'd10;
    localparam logic [ID_W-1:0]  ID_RESET      = 32'd1;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [1:0] {
        ST_UNUSED  = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_DEAD    = 2'd3
    } t_status;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK   = 2'd0,
        REQ_CREATE = 2'd1,
        REQ_EXIT   = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    // One ring table entry
    typedef struct packed {
        t_status status;
        t_slot   succ;
    } t_entry;

    // Ring memory access from the sequencer
    typedef struct packed {
        t_slot  rd_addr;
        logic   we;
        t_slot  wr_addr;
        t_entry wr_data;
    } t_ring_req;

    // Frame memory access from the sequencer
    typedef struct packed {
        t_slot              rd_addr;
        logic               we;
        t_slot              wr_addr;
        logic [FRAME_W-1:0] wr_data;
    } t_frame_req;

endpackage
`default_nettype wire

// ----- rtl/rrts_ring_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_ring_mem
// Status and successor table: one write port, one registered read port.
// Entries never written read back as their reset value via per-entry valid
// bits (slot 0 running and self-linked, all others unused).
// ----------------------------------------------------------------------------
module rrts_ring_mem import rrts_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_ring_req i_req,
    output t_entry         o_rd_data
);

    t_entry                 mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]  r_vld;
    t_entry                 r_rd_raw;
    logic                   r_rd_vld;
    t_slot                  r_rd_addr;

    // Storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_raw  <= mem[i_req.rd_addr];
        r_rd_vld  <= r_vld[i_req.rd_addr];
        r_rd_addr <= i_req.rd_addr;
    end

    // Written-entry flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    // Unwritten entries show their reset contents
    always_comb begin
        if (r_rd_vld) begin
            o_rd_data = r_rd_raw;
        end else begin
            o_rd_data.status = (r_rd_addr == '0) ? ST_RUNNING : ST_UNUSED;
            o_rd_data.succ   = '0;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rrts_frame_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_frame_mem
// Saved frame address per slot: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rrts_frame_mem import rrts_pkg::*; (
    input  wire logic               i_clk,
    input  wire t_frame_req         i_req,
    output logic [FRAME_W-1:0]      o_rd_data
);

    logic [FRAME_W-1:0] mem [SLOT_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        o_rd_data <= mem[i_req.rd_addr];
    end

endmodule
`default_nettype wire

// ----- rtl/rrts_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_ctrl
// Request sequencer: reads the current entry, then creates, exits or runs the
// quantum and ring walk, writing the tables back one entry per cycle.
// ----------------------------------------------------------------------------
module rrts_ctrl import rrts_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // request channel
    input  wire logic                   i_req_valid,
    output logic                        o_req_ready,
    input  wire logic [REQ_W-1:0]       i_req_type,
    input  wire logic [FRAME_W-1:0]     i_frame_ptr,
    // configuration channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [QTM_W-1:0]       i_cfg_quantum_ticks,
    // response channel
    output logic                        o_rsp_valid,
    input  wire logic                   i_rsp_ready,
    output logic                        o_ok,
    output logic                        o_switched,
    output logic [FRAME_W-1:0]          o_resume_frame,
    output logic [OUT_SLOT_W-1:0]       o_new_slot,
    output logic [ID_W-1:0]             o_new_task_id,
    output logic [OUT_SLOT_W-1:0]       o_running_slot,
    // table memories
    output t_ring_req                   o_ring,
    input  wire t_entry                 i_ring_rd,
    output t_frame_req                  o_frame,
    input  wire logic [FRAME_W-1:0]     i_frame_rd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CUR  = 6'b000010,
        S_LINK = 6'b000100,
        S_WALK = 6'b001000,
        S_SW   = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    // control state
    t_state             r_state,   n_state;
    t_slot              r_cur,     n_cur;
    logic [QTM_W-1:0]   r_tick,    n_tick;
    logic [QTM_W-1:0]   r_quantum;
    logic [ID_W-1:0]    r_id,      n_id;
    logic [FILL_W-1:0]  r_fill,    n_fill;
    logic               r_out_vld, n_out_vld;

    // working payload
    t_req               r_req,     n_req;
    logic [FRAME_W-1:0] r_frame,   n_frame;
    t_entry             r_cur_ent, n_cur_ent;
    t_slot              r_cand,    n_cand;

    // pending result
    logic               r_res_ok,     n_res_ok;
    logic               r_res_sw,     n_res_sw;
    logic [FRAME_W-1:0] r_res_resume, n_res_resume;
    t_slot              r_res_nslot,  n_res_nslot;
    logic [ID_W-1:0]    r_res_nid,    n_res_nid;

    // output register
    logic               r_out_ok,     n_out_ok;
    logic               r_out_sw,     n_out_sw;
    logic [FRAME_W-1:0] r_out_resume, n_out_resume;
    t_slot              r_out_nslot,  n_out_nslot;
    logic [ID_W-1:0]    r_out_nid,    n_out_nid;
    t_slot              r_out_run,    n_out_run;

    logic               go;
    logic [QTM_W-1:0]   tick_inc;
    t_slot              free_slot;
    logic               table_full;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign tick_inc    = r_tick + 1'b1;
    assign free_slot   = r_fill[SLOT_W-1:0];
    assign table_full  = (r_fill == FILL_W'(SLOT_COUNT));

    // Sequencer. Tables are only written outside S_IDLE/S_OUT, so the read
    // issued when a beat is taken never overlaps a write of the same item.
    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_tick       = r_tick;
        n_id         = r_id;
        n_fill       = r_fill;
        n_req        = r_req;
        n_frame      = r_frame;
        n_cur_ent    = r_cur_ent;
        n_cand       = r_cand;
        n_res_ok     = r_res_ok;
        n_res_sw     = r_res_sw;
        n_res_resume = r_res_resume;
        n_res_nslot  = r_res_nslot;
        n_res_nid    = r_res_nid;
        n_out_vld    = r_out_vld && !i_rsp_ready;
        n_out_ok     = r_out_ok;
        n_out_sw     = r_out_sw;
        n_out_resume = r_out_resume;
        n_out_nslot  = r_out_nslot;
        n_out_nid    = r_out_nid;
        n_out_run    = r_out_run;
        go           = 1'b0;

        o_ring.rd_addr  = r_cur;
        o_ring.we       = 1'b0;
        o_ring.wr_addr  = r_cur;
        o_ring.wr_data  = i_ring_rd;
        o_frame.rd_addr = r_cand;
        o_frame.we      = 1'b0;
        o_frame.wr_addr = r_cur;
        o_frame.wr_data = r_frame;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req   = t_req'(i_req_type);
                    n_frame = i_frame_ptr;
                    n_state = S_CUR;
                end
            end

            // current entry is on the read port
            S_CUR: begin
                n_cur_ent    = i_ring_rd;
                n_res_ok     = 1'b1;
                n_res_sw     = 1'b0;
                n_res_resume = '0;
                n_res_nslot  = '0;
                n_res_nid    = '0;
                n_state      = S_OUT;
                case (r_req)
                    REQ_TICK: begin
                        go = 1'b1;
                        // a dead task forces expiry without counting
                        if (i_ring_rd.status != ST_DEAD) begin
                            if (tick_inc < r_quantum) begin
                                go     = 1'b0;
                                n_tick = tick_inc;
                            end else begin
                                n_tick = '0;
                            end
                        end
                        if (go) begin
                            o_frame.we     = 1'b1;
                            n_cand         = i_ring_rd.succ;
                            o_ring.rd_addr = i_ring_rd.succ;
                            n_state        = S_WALK;
                        end
                    end
                    REQ_CREATE: begin
                        if (table_full) begin
                            n_res_ok = 1'b0;
                        end else begin
                            o_ring.we             = 1'b1;
                            o_ring.wr_addr        = free_slot;
                            o_ring.wr_data.status = ST_READY;
                            o_ring.wr_data.succ   = i_ring_rd.succ;
                            o_frame.we            = 1'b1;
                            o_frame.wr_addr       = free_slot;
                            n_res_nslot           = free_slot;
                            n_res_nid             = r_id;
                            n_id                  = r_id + 1'b1;
                            n_fill                = r_fill + 1'b1;
                            n_cand                = free_slot;
                            n_state               = S_LINK;
                        end
                    end
                    REQ_EXIT: begin
                        o_ring.we             = 1'b1;
                        o_ring.wr_data.status = ST_DEAD;
                        o_ring.wr_data.succ   = i_ring_rd.succ;
                    end
                    default: begin
                    end
                endcase
            end

            // link the new slot in after the current one
            S_LINK: begin
                o_ring.we             = 1'b1;
                o_ring.wr_data.status = r_cur_ent.status;
                o_ring.wr_data.succ   = r_cand;
                n_state               = S_OUT;
            end

            // one ring entry per cycle
            S_WALK: begin
                if (r_cand == r_cur) begin
                    n_state = S_OUT;
                end else if (i_ring_rd.status == ST_READY) begin
                    o_ring.we             = 1'b1;
                    o_ring.wr_addr        = r_cand;
                    o_ring.wr_data.status = ST_RUNNING;
                    o_ring.wr_data.succ   = i_ring_rd.succ;
                    n_state               = S_SW;
                end else begin
                    n_cand         = i_ring_rd.succ;
                    o_ring.rd_addr = i_ring_rd.succ;
                end
            end

            // hand over: demote the old task if still running, pick up the saved frame
            S_SW: begin
                if (r_cur_ent.status == ST_RUNNING) begin
                    o_ring.we             = 1'b1;
                    o_ring.wr_data.status = ST_READY;
                    o_ring.wr_data.succ   = r_cur_ent.succ;
                end
                n_res_sw     = 1'b1;
                n_res_resume = i_frame_rd;
                n_cur        = r_cand;
                n_state      = S_OUT;
            end

            S_OUT: begin
                if (!r_out_vld || i_rsp_ready) begin
                    n_out_vld    = 1'b1;
                    n_out_ok     = r_res_ok;
                    n_out_sw     = r_res_sw;
                    n_out_resume = r_res_resume;
                    n_out_nslot  = r_res_nslot;
                    n_out_nid    = r_res_nid;
                    n_out_run    = r_cur;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_tick    <= '0;
            r_quantum <= QUANTUM_RESET;
            r_id      <= ID_RESET;
            r_fill    <= FILL_W'(1);
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_tick    <= n_tick;
            r_id      <= n_id;
            r_fill    <= n_fill;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid) begin
                r_quantum <= i_cfg_quantum_ticks;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_frame      <= n_frame;
        r_cur_ent    <= n_cur_ent;
        r_cand       <= n_cand;
        r_res_ok     <= n_res_ok;
        r_res_sw     <= n_res_sw;
        r_res_resume <= n_res_resume;
        r_res_nslot  <= n_res_nslot;
        r_res_nid    <= n_res_nid;
        r_out_ok     <= n_out_ok;
        r_out_sw     <= n_out_sw;
        r_out_resume <= n_out_resume;
        r_out_nslot  <= n_out_nslot;
        r_out_nid    <= n_out_nid;
        r_out_run    <= n_out_run;
    end

    assign o_rsp_valid    = r_out_vld;
    assign o_ok           = r_out_ok;
    assign o_switched     = r_out_sw;
    assign o_resume_frame = r_out_resume;
    assign o_new_slot     = OUT_SLOT_W'(r_out_nslot);
    assign o_new_task_id  = r_out_nid;
    assign o_running_slot = OUT_SLOT_W'(r_out_run);

endmodule
`default_nettype wire

// ----- rtl/round_robin_task_scheduler_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_top
// Round-robin task scheduler with a time quantum over a slot ring.
// ----------------------------------------------------------------------------
// One request is handled at a time; a response beat may wait in the output
// register while the next request is taken. Exit, no-op, full-table create
// and a tick that does not expire go from the current-entry read straight
// to the output register; a successful create adds the link write; an
// expiring tick adds a walk over up to SLOT_COUNT-1 ring entries plus the
// hand-over step if it switches. The ring walk is paced by the single read
// port of the status/successor memory, one entry per cycle. No clearing
// pass is needed after reset. The quantum register may be written whenever
// no request is in flight.
module round_robin_task_scheduler_top import rrts_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_req_valid,
    output logic                        o_req_ready,
    input  wire logic [REQ_W-1:0]       i_req_type,
    input  wire logic [FRAME_W-1:0]     i_frame_ptr,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [QTM_W-1:0]       i_cfg_quantum_ticks,
    output logic                        o_rsp_valid,
    input  wire logic                   i_rsp_ready,
    output logic                        o_ok,
    output logic                        o_switched,
    output logic [FRAME_W-1:0]          o_resume_frame,
    output logic [OUT_SLOT_W-1:0]       o_new_slot,
    output logic [ID_W-1:0]             o_new_task_id,
    output logic [OUT_SLOT_W-1:0]       o_running_slot
);

    t_ring_req          ring_req;
    t_entry             ring_rd;
    t_frame_req         frame_req;
    logic [FRAME_W-1:0] frame_rd;

    rrts_ring_mem u_ring_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ring_req),
        .o_rd_data (ring_rd)
    );

    rrts_frame_mem u_frame_mem (
        .i_clk     (i_clk),
        .i_req     (frame_req),
        .o_rd_data (frame_rd)
    );

    rrts_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req_valid         (i_req_valid),
        .o_req_ready         (o_req_ready),
        .i_req_type          (i_req_type),
        .i_frame_ptr         (i_frame_ptr),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_quantum_ticks (i_cfg_quantum_ticks),
        .o_rsp_valid         (o_rsp_valid),
        .i_rsp_ready         (i_rsp_ready),
        .o_ok                (o_ok),
        .o_switched          (o_switched),
        .o_resume_frame      (o_resume_frame),
        .o_new_slot          (o_new_slot),
        .o_new_task_id       (o_new_task_id),
        .o_running_slot      (o_running_slot),
        .o_ring              (ring_req),
        .i_ring_rd           (ring_rd),
        .o_frame             (frame_req),
        .i_frame_rd          (frame_rd)
    );

endmodule
`default_nettype wire

// ----- rtl/rrts_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks on the scheduler's response channel.
// ----------------------------------------------------------------------------
module rrts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic        o_ok,
    input wire logic        o_switched,
    input wire logic [31:0] o_resume_frame,
    input wire logic [3:0]  o_new_slot,
    input wire logic [31:0] o_new_task_id,
    input wire logic [3:0]  o_running_slot
);

    // stalled response beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_ok) &&
        $stable(o_switched) && $stable(o_resume_frame) && $stable(o_new_slot) &&
        $stable(o_new_task_id) && $stable(o_running_slot))
        else $error("response beat changed while stalled");

    // no response beat straight out of reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid right after reset");

    // failed create carries no switch, new slot or task id
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_ok |-> !o_switched && o_new_slot == 4'd0 &&
        o_new_task_id == 32'd0)
        else $error("failed create carries result fields");

    // a created slot and a task switch never come in one beat
    a_create_no_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_new_slot != 4'd0 |-> o_ok && !o_switched)
        else $error("create beat flags a switch");

endmodule

bind round_robin_task_scheduler_top rrts_checker u_rrts_checker (.*);
`default_nettype wire
